FILE: design/abal_pkg.sv
// Shared constants for the arena block allocator.
`default_nettype none
package abal_pkg;
  localparam int ARENA_DEPTH = 4096;
  localparam int ADDR_W = $clog2(ARENA_DEPTH);
  localparam int AB_W = 13;
  localparam int POS_W = 18;
  localparam int SUM_W = 20;
  localparam int FIELD_W = 12;
  localparam int STAT_W = 3;
  localparam int CMD_W = 2;
  localparam int IN_DATA_W = 32;
  localparam int OUT_DATA_W = 16;

  localparam logic [7:0] TAG_EMPTY = 8'd0;
  localparam logic [7:0] TAG_FULL  = 8'd1;
  localparam logic [7:0] TAG_FREED = 8'd2;
  localparam logic [7:0] TAG_DEAD  = 8'd3;

  localparam int HDR_BYTES = 3;
  localparam int ARENA_HDR = 2;
  localparam int MIN_ARENA = 6;

  localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FREE  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CHECK = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
  localparam logic [STAT_W-1:0] ST_UNINIT   = 3'd1;
  localparam logic [STAT_W-1:0] ST_NOSPACE  = 3'd2;
  localparam logic [STAT_W-1:0] ST_NULL     = 3'd3;
  localparam logic [STAT_W-1:0] ST_FREED    = 3'd4;
  localparam logic [STAT_W-1:0] ST_INACTIVE = 3'd5;
endpackage
`default_nettype wire

FILE: design/arena_block_allocator_top.sv
// Top level of the arena block allocator: command sequencer around the byte arena RAM.
`default_nettype none
// The arena block allocator keeps a byte arena in one RAM and serves allocate,
// free and check commands, one transaction at a time.
// Input transactions arrive on the s_axis group and carry the command, the
// requested size and a handle; each yields one output transaction on the m_axis group
// with a result handle and a status, unless a valid size write cuts its command short.
// The configuration port sets the arena size; a write of 6 or more starts a
// clearing pass over all ARENA_DEPTH (4096) bytes of the RAM, during which no
// transaction is accepted. Writes below 6 are ignored.
// Latency depends on the arena contents: a block header visited is read one byte
// at a time from the registered-read RAM, a dead byte is read on its own, and
// each byte written by a claim or a free takes its own write, as the RAM has
// one write port. Commands that fail their early checks skip the RAM entirely.
// After reset the size is zero and each allocate, free or check answers uninitialised
// (or null handle for a free of handle zero) without touching the RAM.
// The result is held in an output register. If the receiver stalls, that
// transaction waits there while the block accepts and works on the next
// command, whose result then waits in the sequencer until the output register
// is free again; only then is a further command accepted.
module arena_block_allocator_top (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [abal_pkg::AB_W-1:0]        cfg_wdata_i,
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  // [1:0] command, [13:2] request_size, [25:14] handle, rest zero
  input  wire logic [abal_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // [11:0] result_handle, [14:12] status, [15] zero
  output logic      [abal_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);
  import abal_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_CLR  = 4'd1;
  localparam logic [3:0] S_DISP = 4'd2;
  localparam logic [3:0] S_WALK = 4'd3;
  localparam logic [3:0] S_RD1  = 4'd4;
  localparam logic [3:0] S_RD2  = 4'd5;
  localparam logic [3:0] S_RD3  = 4'd6;
  localparam logic [3:0] S_CH0  = 4'd7;
  localparam logic [3:0] S_CH1  = 4'd8;
  localparam logic [3:0] S_CH2  = 4'd9;
  localparam logic [3:0] S_FILL = 4'd10;
  localparam logic [3:0] S_DONE = 4'd11;

  logic [3:0] state_q, state_d;
  logic [AB_W-1:0] ab_q, ab_d;
  logic [ADDR_W:0] clr_q, clr_d;
  logic [CMD_W-1:0] cmd_q, cmd_d;
  logic [FIELD_W-1:0] sz_q, sz_d, h_q, h_d;
  logic [POS_W-1:0] pos_q, pos_d, gap_q, gap_d;
  logic have_q, have_d;
  logic signed [SUM_W-1:0] left_q, left_d, room_q, room_d;
  logic [7:0] tag_q, tag_d, lo_q, lo_d;
  logic [POS_W-1:0] fa_q, fa_d;
  logic [SUM_W-1:0] fc_q, fc_d;
  logic [7:0] fv_q, fv_d;
  logic phase_q, phase_d;
  logic [FIELD_W-1:0] res_q, res_d;
  logic [STAT_W-1:0] st_q, st_d;
  logic ov_q, ov_d;
  logic [FIELD_W-1:0] oh_q, oh_d;
  logic [STAT_W-1:0] os_q, os_d;
  logic rvalid_q, rvalid_d;

  logic [POS_W-1:0] rd_addr, wr_addr, ab_pos, bs_step;
  logic wr_en, ram_we;
  logic [7:0] wr_data, rdata, ram_rdata;
  logic [ADDR_W-1:0] ram_waddr;
  logic signed [SUM_W-1:0] s_s, bs_s, room_n;
  logic [15:0] bs;
  logic uninit;

  assign ab_pos  = POS_W'(ab_q);
  assign s_s     = signed'(SUM_W'(sz_q));
  assign rdata   = rvalid_q ? ram_rdata : TAG_EMPTY;
  assign bs      = {rdata, lo_q};
  assign bs_s    = signed'(SUM_W'(bs)) + SUM_W'(HDR_BYTES);
  assign bs_step = POS_W'(bs) + POS_W'(HDR_BYTES);
  assign uninit  = ab_q < AB_W'(MIN_ARENA);

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = {1'b0, os_q, oh_q};

  // Writes beyond the arena are dropped, except during the clearing pass.
  assign ram_we    = (state_q == S_CLR) ? 1'b1 : (wr_en && (wr_addr < ab_pos));
  assign ram_waddr = (state_q == S_CLR) ? clr_q[ADDR_W-1:0] : wr_addr[ADDR_W-1:0];

  abal_ram #(
    .WIDTH(8),
    .DEPTH(ARENA_DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i((state_q == S_CLR) ? TAG_EMPTY : wr_data),
    .raddr_i(rd_addr[ADDR_W-1:0]),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    state_d = state_q; ab_d = ab_q; clr_d = clr_q;
    cmd_d = cmd_q; sz_d = sz_q; h_d = h_q;
    pos_d = pos_q; gap_d = gap_q; have_d = have_q;
    left_d = left_q; room_d = room_q; tag_d = tag_q; lo_d = lo_q;
    fa_d = fa_q; fc_d = fc_q; fv_d = fv_q; phase_d = phase_q;
    res_d = res_q; st_d = st_q;
    ov_d = ov_q; oh_d = oh_q; os_d = os_q;
    rd_addr = pos_q;
    wr_en = 1'b0; wr_addr = fa_q; wr_data = fv_q;
    room_n = room_q;

    if (ov_q && m_axis_tready) begin
      ov_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          cmd_d = s_axis_tdata[1:0];
          sz_d  = s_axis_tdata[13:2];
          h_d   = s_axis_tdata[25:14];
          state_d = S_DISP;
        end
      end
      S_CLR: begin
        clr_d = clr_q + 1'b1;
        if (clr_q == (ADDR_W+1)'(ARENA_DEPTH - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_DISP: begin
        res_d = '0;
        state_d = S_DONE;
        case (cmd_q)
          CMD_ALLOC: begin
            if (uninit) begin
              st_d = ST_UNINIT;
            end else if (s_s + SUM_W'(HDR_BYTES) >
                         signed'(SUM_W'(ab_q)) - SUM_W'(ARENA_HDR)) begin
              st_d = ST_NOSPACE;
            end else begin
              pos_d = POS_W'(ARENA_HDR);
              left_d = signed'(SUM_W'(ab_q)) - SUM_W'(ARENA_HDR);
              room_d = '0;
              have_d = 1'b0;
              state_d = S_WALK;
            end
          end
          CMD_FREE: begin
            if (h_q == '0) begin
              st_d = ST_NULL;
            end else if (uninit) begin
              st_d = ST_UNINIT;
            end else if (h_q < FIELD_W'(ARENA_HDR + HDR_BYTES) || POS_W'(h_q) > ab_pos) begin
              st_d = ST_INACTIVE;
            end else begin
              pos_d = POS_W'(h_q) - POS_W'(HDR_BYTES);
              rd_addr = pos_d;
              state_d = S_RD1;
            end
          end
          CMD_CHECK: begin
            if (uninit) begin
              st_d = ST_UNINIT;
            end else begin
              pos_d = POS_W'(ARENA_HDR);
              state_d = S_WALK;
            end
          end
          default: st_d = ST_INACTIVE;
        endcase
      end
      S_WALK: begin
        rd_addr = pos_q;
        if (cmd_q == CMD_ALLOC) begin
          if (pos_q < ab_pos && left_q + room_q >= s_s) begin
            state_d = S_RD1;
          end else begin
            st_d = ST_NOSPACE;
            state_d = S_DONE;
          end
        end else begin
          if (pos_q < ab_pos) begin
            state_d = S_RD1;
          end else begin
            st_d = ST_INACTIVE;
            state_d = S_DONE;
          end
        end
      end
      S_RD1: begin
        tag_d = rdata;
        rd_addr = pos_q + 1'b1;
        state_d = S_RD2;
        case (cmd_q)
          CMD_ALLOC: begin
            if (rdata == TAG_EMPTY) begin
              if (left_q + room_q - SUM_W'(HDR_BYTES) < s_s) begin
                st_d = ST_NOSPACE;
                state_d = S_DONE;
              end else begin
                if (!have_q) begin
                  gap_d = pos_q;
                  room_d = '0;
                end
                state_d = S_CH0;
              end
            end else if (rdata == TAG_DEAD) begin
              room_n = have_q ? room_q + 1'b1 : room_q + SUM_W'(1) - SUM_W'(HDR_BYTES);
              if (!have_q) begin
                gap_d = pos_q;
              end
              have_d = 1'b1;
              room_d = room_n;
              if (room_n == s_s) begin
                state_d = S_CH0;
              end else begin
                left_d = left_q - 1'b1;
                pos_d = pos_q + 1'b1;
                state_d = S_WALK;
              end
            end else if (rdata != TAG_FULL && rdata != TAG_FREED) begin
              st_d = ST_NOSPACE;
              state_d = S_DONE;
            end
          end
          CMD_CHECK: begin
            if (pos_q + POS_W'(HDR_BYTES) == POS_W'(h_q)) begin
              st_d = (rdata == TAG_FULL) ? ST_OK : ST_INACTIVE;
              state_d = S_DONE;
            end else if (rdata == TAG_DEAD) begin
              pos_d = pos_q + 1'b1;
              state_d = S_WALK;
            end
          end
          default: begin
            if (rdata == TAG_FREED) begin
              st_d = ST_FREED;
              state_d = S_DONE;
            end
          end
        endcase
      end
      S_RD2: begin
        lo_d = rdata;
        rd_addr = pos_q + POS_W'(2);
        state_d = S_RD3;
      end
      S_RD3: begin
        state_d = S_WALK;
        case (cmd_q)
          CMD_ALLOC: begin
            if (tag_q == TAG_FULL) begin
              left_d = left_q - bs_s;
              pos_d = pos_q + bs_step;
              have_d = 1'b0;
              room_d = '0;
            end else begin
              room_n = have_q ? room_q + bs_s : room_q + signed'(SUM_W'(bs));
              if (!have_q) begin
                gap_d = pos_q;
              end
              have_d = 1'b1;
              room_d = room_n;
              if (room_n >= s_s) begin
                state_d = S_CH0;
              end else begin
                left_d = left_q - bs_s;
                pos_d = pos_q + bs_step;
              end
            end
          end
          CMD_CHECK: begin
            pos_d = pos_q + bs_step;
          end
          default: begin
            // Free: tag the block freed, then zero its data bytes.
            wr_en = 1'b1;
            wr_addr = pos_q;
            wr_data = TAG_FREED;
            fa_d = pos_q + POS_W'(HDR_BYTES);
            fc_d = SUM_W'(bs);
            fv_d = TAG_EMPTY;
            phase_d = 1'b0;
            state_d = S_FILL;
          end
        endcase
      end
      S_CH0: begin
        wr_en = 1'b1; wr_addr = gap_q; wr_data = TAG_FULL;
        state_d = S_CH1;
      end
      S_CH1: begin
        wr_en = 1'b1; wr_addr = gap_q + 1'b1; wr_data = sz_q[7:0];
        state_d = S_CH2;
      end
      S_CH2: begin
        wr_en = 1'b1; wr_addr = gap_q + POS_W'(2);
        wr_data = {4'h0, sz_q[FIELD_W-1:8]};
        fa_d = gap_q + POS_W'(HDR_BYTES);
        fc_d = (room_q < 0) ? '0 : ((room_q < s_s) ? SUM_W'(room_q) : SUM_W'(sz_q));
        fv_d = TAG_EMPTY;
        phase_d = 1'b1;
        state_d = S_FILL;
      end
      S_FILL: begin
        if (fc_q == '0 || fa_q >= ab_pos) begin
          if (phase_q && room_q > s_s) begin
            fa_d = gap_q + POS_W'(HDR_BYTES) + POS_W'(sz_q);
            fc_d = SUM_W'(room_q - s_s);
            fv_d = TAG_DEAD;
            phase_d = 1'b0;
          end else begin
            st_d = ST_OK;
            res_d = (cmd_q == CMD_ALLOC) ? FIELD_W'(gap_q + POS_W'(HDR_BYTES)) : '0;
            state_d = S_DONE;
          end
        end else begin
          wr_en = 1'b1;
          fa_d = fa_q + 1'b1;
          fc_d = fc_q - 1'b1;
        end
      end
      S_DONE: begin
        if (!ov_q || m_axis_tready) begin
          ov_d = 1'b1;
          oh_d = res_q;
          os_d = st_q;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    // A valid size write records the size and restarts the clearing pass.
    if (cfg_we_i && cfg_wdata_i >= AB_W'(MIN_ARENA)) begin
      ab_d = (cfg_wdata_i > AB_W'(ARENA_DEPTH)) ? AB_W'(ARENA_DEPTH) : cfg_wdata_i;
      clr_d = '0;
      state_d = S_CLR;
    end

    rvalid_d = rd_addr < ab_pos;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ab_q <= '0;
      clr_q <= '0;
      ov_q <= 1'b0;
      rvalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ab_q <= ab_d;
      clr_q <= clr_d;
      ov_q <= ov_d;
      rvalid_q <= rvalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d; sz_q <= sz_d; h_q <= h_d;
    pos_q <= pos_d; gap_q <= gap_d; have_q <= have_d;
    left_q <= left_d; room_q <= room_d; tag_q <= tag_d; lo_q <= lo_d;
    fa_q <= fa_d; fc_q <= fc_d; fv_q <= fv_d; phase_q <= phase_d;
    res_q <= res_d; st_q <= st_d; oh_q <= oh_d; os_q <= os_d;
  end
endmodule
`default_nettype wire

FILE: design/abal_ram.sv
// Generic simple dual-port RAM with a registered read.
`default_nettype none
module abal_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire
